// File: design/rpn_pkg.sv
// Shared types and codes for the RPN stack calculator.
package rpn_pkg;

   typedef enum logic [3:0] {
      OP_PUSH  = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DIV   = 4'd4,
      OP_MOD   = 4'd5,
      OP_PRINT = 4'd6,
      OP_PEEK  = 4'd7,
      OP_DUP   = 4'd8,
      OP_SWAP  = 4'd9,
      OP_CLEAR = 4'd10
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_ZERO_DIV = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   // Which operand register feeds a push
   typedef enum logic [1:0] {
      SRC_A,
      SRC_B,
      SRC_RES
   } push_src_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_B,
      S_LAT_B,
      S_POP_A,
      S_LAT_A,
      S_CALC,
      S_MUL,
      S_DIV,
      S_DIV_END,
      S_PUSH_1,
      S_PUSH_2,
      S_PEEK,
      S_PEEK_LAT,
      S_RESP
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         pop;
      logic         peek;
      logic         latch_b;
      logic         latch_a;
      logic         raise_zdiv;
      logic         show;
      logic         calc;
      logic         mul_fin;
      logic         div_fin;
      logic         push;
      push_src_type src;
      logic         clear;
      logic         rsp_load;
      opcode_type   op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic b_zero;
      logic b_int_zero;
      logic div_busy;
      logic out_free;
   } dp_stat_type;

endpackage

// File: design/rpn_divider.sv
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module rpn_divider #(
   parameter int QW = 49
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic          busy,
   output logic [QW-1:0] quotient,
   output logic [31:0]   remainder
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [32:0]   rem_sh;
   logic          ge;

   // One shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[QW-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         quo_in  = {quo_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = cnt_ff != CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: design/rpn_datapath.sv
// Stack memory, operand registers, arithmetic and result register.
module rpn_datapath #(
   parameter int STACK_DEPTH = 128,
   parameter int FRAC_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rpn_pkg::dp_cmd_type cmd,
   output rpn_pkg::dp_stat_type stat,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result,
   output logic                rsp_has_value,
   output logic [2:0]          rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int QW = 33 + FRAC_BITS;

   logic [31:0]          stack_mem [STACK_DEPTH];
   logic [31:0]          rd_data_ff;
   logic                 pop_ok_ff;
   logic [SW-1:0]        sp_ff;
   logic [SW-1:0]        sp_dec;
   logic signed [31:0]   a_ff, b_ff, res_ff;
   logic signed [63:0]   prod_ff;
   rpn_pkg::status_type  status_ff;
   logic signed [31:0]   shown_ff;
   logic                 has_ff;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_result_ff;
   logic                 rsp_has_ff;
   logic [2:0]           rsp_status_ff;

   logic signed [31:0]   pop_val;
   logic [31:0]          mag_a, mag_b, mag_pop;
   logic                 div_busy;
   logic [QW-1:0]        quotient, dividend;
   logic [31:0]          remainder, divisor;
   logic signed [32:0]   sum33;
   logic signed [63:0]   prod_sh;
   logic signed [31:0]   calc_res, fin_res;
   logic                 calc_ovf, fin_ovf;
   logic [31:0]          push_val;
   logic [31:0]          rem_s;

   assign sp_dec  = sp_ff - SW'(1);
   assign pop_val = pop_ok_ff ? $signed(rd_data_ff) : 32'sd0;
   assign mag_a   = a_ff[31] ? 32'(-a_ff) : a_ff;
   assign mag_b   = b_ff[31] ? 32'(-b_ff) : b_ff;
   assign mag_pop = pop_val[31] ? 32'(-pop_val) : pop_val;

   // Divider operands: scaled dividend for div, integer parts for mod
   assign dividend = (cmd.op == rpn_pkg::OP_MOD) ? QW'(mag_a >> FRAC_BITS)
                                                 : QW'(mag_a) << FRAC_BITS;
   assign divisor  = (cmd.op == rpn_pkg::OP_MOD) ? (mag_b >> FRAC_BITS) : mag_b;

   rpn_divider #(.QW(QW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.calc && (cmd.op == rpn_pkg::OP_DIV || cmd.op == rpn_pkg::OP_MOD)),
      .dividend  (dividend),
      .divisor   (divisor),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Add / subtract with saturation
   always_comb begin
      if (cmd.op == rpn_pkg::OP_SUB) sum33 = 33'(a_ff) - 33'(b_ff);
      else                           sum33 = 33'(a_ff) + 33'(b_ff);
      calc_ovf = sum33[32] != sum33[31];
      if (!calc_ovf)     calc_res = sum33[31:0];
      else if (sum33[32]) calc_res = 32'sh8000_0000;
      else               calc_res = 32'sh7FFF_FFFF;
   end

   // Finishing step of mul, div and mod
   always_comb begin
      prod_sh = prod_ff >>> FRAC_BITS;
      rem_s   = a_ff[31] ? 32'(-remainder) : remainder;
      fin_res = '0;
      fin_ovf = 1'b0;
      if (cmd.mul_fin) begin
         if (prod_sh > 64'sh7FFF_FFFF) begin
            fin_res = 32'sh7FFF_FFFF;
            fin_ovf = 1'b1;
         end else if (prod_sh < -64'sh8000_0000) begin
            fin_res = 32'sh8000_0000;
            fin_ovf = 1'b1;
         end else begin
            fin_res = prod_sh[31:0];
         end
      end else if (cmd.op == rpn_pkg::OP_MOD) begin
         fin_res = rem_s << FRAC_BITS;
      end else if (a_ff[31] ^ b_ff[31]) begin
         if (quotient[QW-1:32] != '0 || (quotient[31] && quotient[30:0] != '0)) begin
            fin_res = 32'sh8000_0000;
            fin_ovf = 1'b1;
         end else begin
            fin_res = 32'(-quotient[31:0]);
         end
      end else begin
         if (quotient[QW-1:31] != '0) begin
            fin_res = 32'sh7FFF_FFFF;
            fin_ovf = 1'b1;
         end else begin
            fin_res = quotient[31:0];
         end
      end
   end

   always_comb begin
      unique case (cmd.src)
         rpn_pkg::SRC_A:   push_val = a_ff;
         rpn_pkg::SRC_B:   push_val = b_ff;
         rpn_pkg::SRC_RES: push_val = res_ff;
         default:          push_val = res_ff;
      endcase
   end

   // Stack memory: one write or one read per cycle, read data registered
   always_ff @(posedge clock) begin
      if (cmd.push && sp_ff < SW'(STACK_DEPTH)) begin
         stack_mem[sp_ff[AW-1:0]] <= push_val;
      end
      if (cmd.pop || cmd.peek) begin
         rd_data_ff <= stack_mem[sp_dec[AW-1:0]];
      end
   end

   // Control state: pointer, status, result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         status_ff    <= rpn_pkg::STAT_OK;
         pop_ok_ff    <= 1'b0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            status_ff <= rpn_pkg::STAT_OK;
            has_ff    <= 1'b0;
         end
         if (cmd.pop || cmd.peek) begin
            pop_ok_ff <= sp_ff != '0;
            if (sp_ff == '0) begin
               if (status_ff == rpn_pkg::STAT_OK) status_ff <= rpn_pkg::STAT_EMPTY;
            end else if (cmd.pop) begin
               sp_ff <= sp_dec;
            end
         end
         if (cmd.raise_zdiv && status_ff == rpn_pkg::STAT_OK) begin
            status_ff <= rpn_pkg::STAT_ZERO_DIV;
         end
         if (cmd.calc && (cmd.op == rpn_pkg::OP_ADD || cmd.op == rpn_pkg::OP_SUB)
             && calc_ovf && status_ff == rpn_pkg::STAT_OK) begin
            status_ff <= rpn_pkg::STAT_OVERFLOW;
         end
         if ((cmd.mul_fin || cmd.div_fin) && fin_ovf && status_ff == rpn_pkg::STAT_OK) begin
            status_ff <= rpn_pkg::STAT_OVERFLOW;
         end
         if (cmd.push) begin
            if (sp_ff < SW'(STACK_DEPTH)) begin
               sp_ff <= sp_ff + SW'(1);
            end else if (status_ff == rpn_pkg::STAT_OK) begin
               status_ff <= rpn_pkg::STAT_FULL;
            end
         end
         if (cmd.clear) sp_ff <= '0;
         if (cmd.show)  has_ff <= pop_ok_ff;
         if (cmd.rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   // Operand and result payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff     <= req_value;
         shown_ff <= '0;
      end
      if (cmd.latch_b) b_ff <= pop_val;
      if (cmd.latch_a) a_ff <= pop_val;
      if (cmd.calc)    res_ff <= calc_res;
      if (cmd.calc)    prod_ff <= 64'(a_ff) * 64'(b_ff);
      if (cmd.mul_fin || cmd.div_fin) res_ff <= fin_res;
      if (cmd.show)    shown_ff <= pop_val;
      if (cmd.rsp_load) begin
         rsp_result_ff <= shown_ff;
         rsp_has_ff    <= has_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign stat.b_zero     = pop_val == 32'sd0;
   assign stat.b_int_zero = (mag_pop >> FRAC_BITS) == 32'd0;
   assign stat.div_busy   = div_busy;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_result_ff;
   assign rsp_has_value = rsp_has_ff;
   assign rsp_status    = rsp_status_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> sp_ff == '0)
      else $error("clear left entries on the stack");

   a_shown_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_has_ff |-> rsp_status_ff == rpn_pkg::STAT_OK)
      else $error("shown value with fault status");

   a_no_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_result_ff == 32'sd0)
      else $error("result nonzero without a shown value");

endmodule

// File: design/rpn_ctrl.sv
// Command sequencer: steps each item through pops, compute and pushes.
module rpn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_opcode,
   input  rpn_pkg::dp_stat_type stat,
   output rpn_pkg::dp_cmd_type  cmd
);

   rpn_pkg::ctrl_state_type state_ff, state_in;
   rpn_pkg::opcode_type     op_ff, op_in;
   rpn_pkg::opcode_type     req_op;

   assign req_op = rpn_pkg::opcode_type'(req_opcode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::S_IDLE;
         op_ff    <= rpn_pkg::OP_PUSH;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      cmd.src   = rpn_pkg::SRC_RES;
      req_ready = state_ff == rpn_pkg::S_IDLE;
      unique case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               unique case (req_op)
                  rpn_pkg::OP_PUSH:  state_in = rpn_pkg::S_PUSH_1;
                  rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
                  rpn_pkg::OP_MOD, rpn_pkg::OP_PRINT, rpn_pkg::OP_SWAP:
                                     state_in = rpn_pkg::S_POP_B;
                  rpn_pkg::OP_PEEK:  state_in = rpn_pkg::S_PEEK;
                  rpn_pkg::OP_DUP:   state_in = rpn_pkg::S_POP_A;
                  rpn_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = rpn_pkg::S_RESP;
                  end
                  default:           state_in = rpn_pkg::S_RESP;
               endcase
            end
         end
         rpn_pkg::S_POP_B: begin
            cmd.pop  = 1'b1;
            state_in = rpn_pkg::S_LAT_B;
         end
         rpn_pkg::S_LAT_B: begin
            cmd.latch_b = 1'b1;
            priority if (op_ff == rpn_pkg::OP_PRINT) begin
               cmd.show = 1'b1;
               state_in = rpn_pkg::S_RESP;
            end else if ((op_ff == rpn_pkg::OP_DIV && stat.b_zero) ||
                         (op_ff == rpn_pkg::OP_MOD && stat.b_int_zero)) begin
               cmd.raise_zdiv = 1'b1;
               state_in       = rpn_pkg::S_RESP;
            end else begin
               state_in = rpn_pkg::S_POP_A;
            end
         end
         rpn_pkg::S_POP_A: begin
            cmd.pop  = 1'b1;
            state_in = rpn_pkg::S_LAT_A;
         end
         rpn_pkg::S_LAT_A: begin
            cmd.latch_a = 1'b1;
            if (op_ff == rpn_pkg::OP_DUP || op_ff == rpn_pkg::OP_SWAP) begin
               state_in = rpn_pkg::S_PUSH_1;
            end else begin
               state_in = rpn_pkg::S_CALC;
            end
         end
         rpn_pkg::S_CALC: begin
            cmd.calc = 1'b1;
            unique case (op_ff)
               rpn_pkg::OP_MUL:                 state_in = rpn_pkg::S_MUL;
               rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_in = rpn_pkg::S_DIV;
               default:                          state_in = rpn_pkg::S_PUSH_1;
            endcase
         end
         rpn_pkg::S_MUL: begin
            cmd.mul_fin = 1'b1;
            state_in    = rpn_pkg::S_PUSH_1;
         end
         rpn_pkg::S_DIV: begin
            if (!stat.div_busy) state_in = rpn_pkg::S_DIV_END;
         end
         rpn_pkg::S_DIV_END: begin
            cmd.div_fin = 1'b1;
            state_in    = rpn_pkg::S_PUSH_1;
         end
         rpn_pkg::S_PUSH_1: begin
            cmd.push = 1'b1;
            unique case (op_ff)
               rpn_pkg::OP_PUSH, rpn_pkg::OP_DUP: cmd.src = rpn_pkg::SRC_A;
               rpn_pkg::OP_SWAP:                  cmd.src = rpn_pkg::SRC_B;
               default:                           cmd.src = rpn_pkg::SRC_RES;
            endcase
            if (op_ff == rpn_pkg::OP_DUP || op_ff == rpn_pkg::OP_SWAP) begin
               state_in = rpn_pkg::S_PUSH_2;
            end else begin
               state_in = rpn_pkg::S_RESP;
            end
         end
         rpn_pkg::S_PUSH_2: begin
            cmd.push = 1'b1;
            cmd.src  = rpn_pkg::SRC_A;
            state_in = rpn_pkg::S_RESP;
         end
         rpn_pkg::S_PEEK: begin
            cmd.peek = 1'b1;
            state_in = rpn_pkg::S_PEEK_LAT;
         end
         rpn_pkg::S_PEEK_LAT: begin
            cmd.show = 1'b1;
            state_in = rpn_pkg::S_RESP;
         end
         rpn_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = rpn_pkg::S_IDLE;
            end
         end
         default: state_in = rpn_pkg::S_IDLE;
      endcase
   end

   a_div_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpn_pkg::S_DIV && stat.div_busy |=> state_ff == rpn_pkg::S_DIV)
      else $error("left divide wait while divider busy");

endmodule

// File: design/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: sequencer plus datapath.
//
//   channel  dir  ports                                    item
//   req      in   req_valid/req_ready, req_opcode, req_value  one command
//   rsp      out  rsp_valid/rsp_ready, rsp_result,           one result per command
//                 rsp_has_value, rsp_status
//
// Each item steps through the sequencer states; div/mod wait in S_DIV while the
// radix-2 divider runs, and every item waits in S_RESP for the output register.
// One item is in work at a time; the next is taken once the result is in the
// output register, which holds it until rsp_ready.
// Reset clears the stack pointer (stack empty); the stack memory is not cleared.
module rpn_stack_calculator_unit #(
   parameter int STACK_DEPTH = 128,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_has_value,
   output logic [2:0]         rsp_status
);

   rpn_pkg::dp_cmd_type  cmd;
   rpn_pkg::dp_stat_type stat;

   rpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   rpn_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .rsp_has_value (rsp_has_value),
      .rsp_status    (rsp_status)
   );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the RPN stack calculator unit.
module testbench;

   localparam int DEPTH = 128;
   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] value;
   } item_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               has_value;
      logic [2:0]         status;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_opcode = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_has_value;
   logic [2:0]         rsp_status;

   rpn_stack_calculator_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Calculator state mirror
   logic signed [31:0] calc_stack [DEPTH];
   int                 calc_depth = 0;
   logic [2:0]         calc_fault;

   item_type   pending_cmds[$];
   answer_type expected_answers[$];
   int         errors = 0;
   int         cycles = 0;
   bit         hold_sender = 1'b0;
   bit         stim_done = 1'b0;

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void note_fault(logic [2:0] code);
      if (calc_fault == rpn_pkg::STAT_OK) calc_fault = code;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         note_fault(rpn_pkg::STAT_OVERFLOW);
         return 32'sh7fffffff;
      end
      if (x < -64'sd2147483648) begin
         note_fault(rpn_pkg::STAT_OVERFLOW);
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic void stack_push(logic signed [31:0] v);
      if (calc_depth < DEPTH) begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end else note_fault(rpn_pkg::STAT_FULL);
   endfunction

   function automatic logic signed [31:0] stack_pop();
      if (calc_depth > 0) begin
         calc_depth--;
         return calc_stack[calc_depth];
      end
      note_fault(rpn_pkg::STAT_EMPTY);
      return 0;
   endfunction

   // Compute the answer of one command and update the mirror
   function automatic answer_type run_command(item_type c);
      answer_type ans;
      logic signed [31:0] a, b;
      logic signed [63:0] wide, ai, bi;
      ans = '0;
      calc_fault = rpn_pkg::STAT_OK;
      case (c.opcode)
         rpn_pkg::OP_PUSH: stack_push(c.value);
         rpn_pkg::OP_ADD: begin
            b = stack_pop(); a = stack_pop();
            stack_push(clamp32(64'(a) + 64'(b)));
         end
         rpn_pkg::OP_SUB: begin
            b = stack_pop(); a = stack_pop();
            stack_push(clamp32(64'(a) - 64'(b)));
         end
         rpn_pkg::OP_MUL: begin
            b = stack_pop(); a = stack_pop();
            wide = 64'(a) * 64'(b);
            stack_push(clamp32(wide >>> FRAC));
         end
         rpn_pkg::OP_DIV: begin
            b = stack_pop();
            if (b == 0) note_fault(rpn_pkg::STAT_ZERO_DIV);
            else begin
               a = stack_pop();
               wide = (64'(a) <<< FRAC) / 64'(b);
               stack_push(clamp32(wide));
            end
         end
         rpn_pkg::OP_MOD: begin
            b = stack_pop();
            bi = 64'(b) / (64'sd1 <<< FRAC);
            if (bi == 0) note_fault(rpn_pkg::STAT_ZERO_DIV);
            else begin
               a = stack_pop();
               ai = 64'(a) / (64'sd1 <<< FRAC);
               stack_push(clamp32((ai % bi) <<< FRAC));
            end
         end
         rpn_pkg::OP_PRINT, rpn_pkg::OP_PEEK: begin
            if (calc_depth > 0) begin
               ans.result = calc_stack[calc_depth - 1];
               ans.has_value = 1'b1;
               if (c.opcode == rpn_pkg::OP_PRINT) calc_depth--;
            end else note_fault(rpn_pkg::STAT_EMPTY);
         end
         rpn_pkg::OP_DUP: begin
            a = stack_pop();
            stack_push(a);
            stack_push(a);
         end
         rpn_pkg::OP_SWAP: begin
            b = stack_pop(); a = stack_pop();
            stack_push(b);
            stack_push(a);
         end
         rpn_pkg::OP_CLEAR: calc_depth = 0;
         default: ;
      endcase
      ans.status = calc_fault;
      return ans;
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 6))
         0: return $urandom_range(0, 8) <<< FRAC;
         1: return -($urandom_range(0, 8) <<< FRAC);
         2: return 32'sh7fffffff;
         3: return 32'sh80000000;
         4: return $signed($urandom_range(0, 131071)) - 65536;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_cmd(logic [3:0] op, logic signed [31:0] v);
      item_type c;
      c.opcode = op;
      c.value = v;
      pending_cmds.push_back(c);
   endfunction

   // Driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_answers.push_back(run_command(pending_cmds.pop_front()));
            send_gap = rand_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !hold_sender) begin
               req_valid <= 1'b1;
               req_opcode <= pending_cmds[0].opcode;
               req_value <= pending_cmds[0].value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      answer_type want;
      cycles++;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected item result=%h has=%b status=%0d", $time,
                        rsp_result, rsp_has_value, rsp_status);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_result !== want.result) begin
                  $display("%0t: result expected %h actual %h", $time, want.result,
                           rsp_result);
                  errors++;
               end
               if (rsp_has_value !== want.has_value) begin
                  $display("%0t: has_value expected %b actual %b", $time,
                           want.has_value, rsp_has_value);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  errors++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap = rand_gap();
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      int n, k;
      // Directed: empty-stack faults, every operation, extremes
      add_cmd(rpn_pkg::OP_PRINT, 0);
      add_cmd(rpn_pkg::OP_PEEK, 0);
      add_cmd(rpn_pkg::OP_ADD, 0);
      add_cmd(rpn_pkg::OP_DUP, 0);
      add_cmd(rpn_pkg::OP_SWAP, 0);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh7fffffff);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh7fffffff);
      add_cmd(rpn_pkg::OP_ADD, 0);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh80000000);
      add_cmd(rpn_pkg::OP_SUB, 0);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh00030000);
      add_cmd(rpn_pkg::OP_MUL, 0);
      add_cmd(rpn_pkg::OP_PUSH, 0);
      add_cmd(rpn_pkg::OP_DIV, 0);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh00008000);
      add_cmd(rpn_pkg::OP_MOD, 0);
      add_cmd(rpn_pkg::OP_PUSH, -32'sh00050000);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh00030000);
      add_cmd(rpn_pkg::OP_MOD, 0);
      add_cmd(rpn_pkg::OP_PUSH, 32'sh00000001);
      add_cmd(rpn_pkg::OP_DIV, 0);
      add_cmd(rpn_pkg::OP_PEEK, 0);
      add_cmd(4'd15, -1);
      add_cmd(rpn_pkg::OP_CLEAR, 0);
      // Overfill the stack
      for (int i = 0; i < DEPTH + 2; i++) add_cmd(rpn_pkg::OP_PUSH, rand_value());
      add_cmd(rpn_pkg::OP_DUP, 0);
      add_cmd(rpn_pkg::OP_CLEAR, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Random phase: mostly pushes and arithmetic, the rest anything
      n = 0;
      while (n < 1200) begin
         if (n == 600) begin
            wait (pending_cmds.size() == 0);
            hold_sender = 1'b1;
            wait (expected_answers.size() == 0);
            hold_sender = 1'b0;
         end
         k = $urandom_range(0, 99);
         if (k < 40) add_cmd(rpn_pkg::OP_PUSH, rand_value());
         else if (k < 90)
            add_cmd(4'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_SWAP)), $urandom());
         else if (k < 93) add_cmd(rpn_pkg::OP_CLEAR, $urandom());
         else add_cmd(4'($urandom_range(0, 15)), $urandom());
         n++;
      end
      wait (pending_cmds.size() == 0 && expected_answers.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule

// File: filelist.f
design/rpn_pkg.sv
design/rpn_divider.sv
design/rpn_datapath.sv
design/rpn_ctrl.sv
design/rpn_stack_calculator_unit.sv
tb/testbench.sv
